@@ hw/rtl/hmlf_pkg.sv @@
package hmlf_pkg;

	typedef enum logic [8:0] {
		PH_LEAD  = 9'b000000001,
		PH_HEAD  = 9'b000000010,
		PH_CSIZE = 9'b000000100,
		PH_CDATA = 9'b000001000,
		PH_CCRLF = 9'b000010000,
		PH_TRAIL = 9'b000100000,
		PH_DONE  = 9'b001000000,
		PH_TOEND = 9'b010000000,
		PH_FAIL  = 9'b100000000
	} phase_t;

	localparam logic [1:0] KW_NONE = 2'd0;
	localparam logic [1:0] KW_CLEN = 2'd1;
	localparam logic [1:0] KW_TENC = 2'd2;

	localparam int CLEN_KEY_LEN  = 15;
	localparam int TENC_KEY_LEN  = 18;
	localparam int CLEN_MIN_LINE = 17;
	localparam int TENC_MIN_LINE = 26;

	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_HT = 8'h09;

	localparam logic [1:0] REG_CONN_CLOSED = 2'd0;
	localparam logic [1:0] REG_HEAD_REQ    = 2'd1;
	localparam logic [1:0] REG_CONNECT_REQ = 2'd2;

	typedef struct packed {
		logic conn_closed;
		logic head_request;
		logic connect_request;
	} cfg_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_dig(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
	endfunction

	// Hex digit value, 16 when the octet is not a hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [7:0] l;
		l = to_lower(b);
		if (is_dig(b)) return {1'b0, b[3:0]};
		if (l >= 8'h61 && l <= 8'h66) return 5'(l - 8'h57);
		return 5'd16;
	endfunction

	function automatic logic [7:0] clen_char(input logic [4:0] i);
		logic [7:0] r;
		case (i)
			5'd0: r = "c"; 5'd1: r = "o"; 5'd2: r = "n"; 5'd3: r = "t";
			5'd4: r = "e"; 5'd5: r = "n"; 5'd6: r = "t"; 5'd7: r = "-";
			5'd8: r = "l"; 5'd9: r = "e"; 5'd10: r = "n"; 5'd11: r = "g";
			5'd12: r = "t"; 5'd13: r = "h"; 5'd14: r = ":";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] tenc_char(input logic [4:0] i);
		logic [7:0] r;
		case (i)
			5'd0: r = "t"; 5'd1: r = "r"; 5'd2: r = "a"; 5'd3: r = "n";
			5'd4: r = "s"; 5'd5: r = "f"; 5'd6: r = "e"; 5'd7: r = "r";
			5'd8: r = "-"; 5'd9: r = "e"; 5'd10: r = "n"; 5'd11: r = "c";
			5'd12: r = "o"; 5'd13: r = "d"; 5'd14: r = "i"; 5'd15: r = "n";
			5'd16: r = "g"; 5'd17: r = ":";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] chunk_char(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = "c"; 3'd1: r = "h"; 3'd2: r = "u"; 3'd3: r = "n";
			3'd4: r = "k"; 3'd5: r = "e"; 3'd6: r = "d";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] http_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0: r = "H"; 4'd1: r = "T"; 4'd2: r = "T"; 4'd3: r = "P";
			4'd4: r = "/";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/http1_message_length_framer_top.sv @@
// The result of a last octet is registered in the parser, then in the output register; a held output can delay it.
// Throughput: one octet per cycle while in_stall is low; the parser register updates on every accepted octet.
// The result path holds an output register and one skid entry. The octet input is stalled while
// the skid entry is taken, and in a cycle where a result arrives while the output register is held.
// Reset (arst_n low) clears registers to zero and the parser to its leading-line state.
module http1_message_length_framer_top import hmlf_pkg::*; #(
	parameter int LENGTH_WIDTH = 32,
	parameter int MIN_MESSAGE  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        complete,
	output logic [30:0] message_length
);

	cfg_t        cfg;
	logic        acc;
	logic        res_valid, res_complete;
	logic [30:0] res_length;

	// An octet is taken whenever it is offered and the result path can still hold a request.
	assign acc = in_valid && !in_stall;

	hmlf_cfg_regs u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	// The parser walks the whole RFC 7230 framing state in one step per octet.
	hmlf_parser #(.LENGTH_WIDTH(LENGTH_WIDTH), .MIN_MESSAGE(MIN_MESSAGE)) u_parser (
		.clk, .arst_n, .cfg,
		.in_valid(acc), .in_byte(data_byte), .in_last(last_byte),
		.res_valid, .res_complete, .res_length
	);

	hmlf_out_skid u_skid (
		.clk, .arst_n,
		.in_valid(res_valid), .in_complete(res_complete), .in_length(res_length),
		.in_stall,
		.out_valid, .out_complete(complete), .out_length(message_length),
		.out_stall
	);

	// An incomplete request carries a zero length.
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !complete |-> message_length == '0)
		else $error("incomplete result with nonzero length");

	// A result only follows the last octet of a buffer.
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(acc && last_byte))
		else $error("result without last octet");

	// A complete request always carries a nonzero length.
	a_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && complete |-> message_length != '0)
		else $error("complete result with zero length");

endmodule

@@ hw/rtl/hmlf_cfg_regs.sv @@
module hmlf_cfg_regs import hmlf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic [1:0] idx;

	assign idx = paddr[3:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_CONN_CLOSED: cfg_q.conn_closed     <= pwdata[0];
				REG_HEAD_REQ:    cfg_q.head_request    <= pwdata[0];
				REG_CONNECT_REQ: cfg_q.connect_request <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_CONN_CLOSED: prdata[0] = cfg_q.conn_closed;
			REG_HEAD_REQ:    prdata[0] = cfg_q.head_request;
			REG_CONNECT_REQ: prdata[0] = cfg_q.connect_request;
			default: prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/hmlf_parser.sv @@
module hmlf_parser import hmlf_pkg::*; #(
	parameter int LENGTH_WIDTH = 32,
	parameter int MIN_MESSAGE  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        res_valid,
	output logic        res_complete,
	output logic [30:0] res_length
);

	localparam int LW = LENGTH_WIDTH;
	localparam logic [LW-1:0] LEN_MAX = {1'b0, {(LW-1){1'b1}}};
	localparam logic [LW-1:0] OUT_MAX = (LW > 31) ? LW'(32'h7fffffff) : LEN_MAX;

	phase_t        phase_q;
	logic [LW-1:0] byte_count_q, line_length_q, number_accum_q, clen_value_q;
	logic [LW-1:0] chunk_rem_q, hdr_end_q, result_len_q;
	logic          fold_q, is_resp_q, clen_valid_q, chunked_q;
	logic [3:0]    sl_step_q;
	logic [9:0]    status_q;
	logic [1:0]    kw_q;
	logic [2:0]    cm_q, np_q;

	phase_t        ph;
	logic [LW-1:0] bc, ll, na, clv, cr, he, rl;
	logic          fp, isr, clvd, chs;
	logic [3:0]    ss;
	logic [9:0]    sc;
	logic [1:0]    kw;
	logic [2:0]    cm, np;
	logic          ok;
	logic [LW-1:0] olen;

	function automatic logic [LW-1:0] sat_inc(input logic [LW-1:0] a);
		return (a >= LEN_MAX) ? LEN_MAX : a + 1'b1;
	endfunction

	function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] a, input logic [LW-1:0] b);
		logic [LW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[LW-1:0];
	endfunction

	// Shift-and-add digit step, base 10 or 16; saturates at the length ceiling.
	function automatic logic [LW-1:0] sat_digit(input logic [LW-1:0] acc, input logic hex,
			input logic [3:0] d);
		logic [LW+4:0] p;
		p = hex ? ({5'b0, acc} << 4) : (({5'b0, acc} << 3) + ({5'b0, acc} << 1));
		p = p + (LW+5)'(d);
		return (p > (LW+5)'(LEN_MAX)) ? LEN_MAX : p[LW-1:0];
	endfunction

	function automatic logic [9:0] st_digit(input logic [9:0] s, input logic [7:0] b);
		logic [13:0] t;
		if (s >= 10'd1000) return s;
		t = 14'(s) * 14'd10 + 14'(b[3:0]);
		return (t > 14'd1000) ? 10'd1000 : t[9:0];
	endfunction

	always_comb begin
		logic [7:0] b, lb;
		logic       wsb, dg, sg, xx, le;
		logic [4:0] hv;
		logic       neg;
		b = in_byte;
		ph = phase_q; bc = byte_count_q; ll = line_length_q; na = number_accum_q;
		clv = clen_value_q; cr = chunk_rem_q; he = hdr_end_q; rl = result_len_q;
		fp = fold_q; isr = is_resp_q; clvd = clen_valid_q; chs = chunked_q;
		ss = sl_step_q; sc = status_q; kw = kw_q; cm = cm_q; np = np_q;
		lb = to_lower(b); wsb = is_ws(b); dg = is_dig(b);
		sg = (b == "+") || (b == "-"); xx = (b == "x") || (b == "X");
		hv = hex_val(b);
		le = 1'b0; neg = 1'b0;
		ok = 1'b0; olen = '0;

		// A pending line feed either folds (SP/HT) or closes the header line.
		if (ph == PH_HEAD && fp) begin
			if (b == CH_SP || b == CH_HT) fp = 1'b0;
			else le = 1'b1;
		end
		if (le) begin
			if (ll == LW'(2)) begin
				he = bc;
				if (isr && (cfg.head_request || sc == 10'd204 || sc == 10'd304 ||
						(sc >= 10'd100 && sc <= 10'd199))) begin
					rl = he; ph = PH_DONE;
				end else if (isr && cfg.connect_request && sc >= 10'd200 &&
						sc <= 10'd299) begin
					rl = he; ph = PH_DONE;
				end else if (chs) ph = PH_CSIZE;
				else if (clvd) begin rl = sat_add(he, clv); ph = PH_DONE; end
				else if (!isr) begin rl = he; ph = PH_DONE; end
				else if (cfg.conn_closed) ph = PH_TOEND;
				else ph = PH_FAIL;
			end else begin
				if (kw == KW_CLEN && ll > LW'(CLEN_MIN_LINE)) begin
					neg = (np == 3'd4) || (np == 3'd6);
					clvd = !(neg && na != '0);
					clv = neg ? '0 : na;
				end
				if (kw == KW_TENC && ll > LW'(TENC_MIN_LINE) && cm == 3'd7) chs = 1'b1;
			end
			ll = '0; fp = 1'b0; kw = KW_NONE; cm = '0; np = '0; na = '0; ss = '0;
		end

		bc = sat_inc(bc);

		case (ph)
			PH_LEAD: begin
				if (ss < 4'd14) begin
					if (b == 8'h00) ss = (ss == 4'd13) ? 4'd14 : 4'd15;
					else begin
						case (ss)
							4'd0, 4'd1, 4'd2, 4'd3, 4'd4:
								ss = (b == http_char(ss)) ? ss + 4'd1 : 4'd15;
							4'd5, 4'd8:
								ss = wsb ? ss : sg ? ss + 4'd1 : dg ? ss + 4'd2 : 4'd15;
							4'd6, 4'd9: ss = dg ? ss + 4'd1 : 4'd15;
							4'd7: ss = dg ? 4'd7 : (b == ".") ? 4'd8 : 4'd15;
							4'd10, 4'd11: begin
								if (dg) begin
									if (ss == 4'd11) begin sc = st_digit(sc, b); ss = 4'd13; end
								end else if (sg) begin
									if (b == "-") sc = 10'd1023;
									ss = 4'd12;
								end else ss = wsb ? 4'd11 : 4'd15;
							end
							4'd12: begin
								if (dg) begin sc = st_digit(sc, b); ss = 4'd13; end
								else ss = 4'd15;
							end
							default: begin
								if (dg) sc = st_digit(sc, b); else ss = 4'd14;
							end
						endcase
					end
				end
				ll = sat_inc(ll);
				if (b == CH_LF) begin
					if (ll == LW'(2)) sc = '0;
					else begin isr = (ss == 4'd14); ph = PH_HEAD; end
					ll = '0; fp = 1'b0; kw = KW_NONE; cm = '0; np = '0; na = '0; ss = '0;
				end
			end
			PH_HEAD: begin
				if (ll == '0) begin
					kw = (lb == "c") ? KW_CLEN : (lb == "t") ? KW_TENC : KW_NONE;
				end else if (kw == KW_CLEN) begin
					if (ll < LW'(CLEN_KEY_LEN)) begin
						if (lb != clen_char(ll[4:0])) kw = KW_NONE;
					end else begin
						case (np)
							3'd0: begin
								if (!wsb) begin
									if (b == "+") np = 3'd1;
									else if (b == "-") np = 3'd2;
									else if (dg) begin na = LW'(b[3:0]); np = 3'd3; end
									else np = 3'd5;
								end
							end
							3'd1, 3'd2: begin
								if (dg) begin na = LW'(b[3:0]); np = np + 3'd2; end
								else np = np + 3'd4;
							end
							3'd3, 3'd4: begin
								if (dg) na = sat_digit(na, 1'b0, b[3:0]);
								else np = np + 3'd2;
							end
							default: ;
						endcase
					end
				end else if (kw == KW_TENC) begin
					if (ll < LW'(TENC_KEY_LEN)) begin
						if (lb != tenc_char(ll[4:0])) kw = KW_NONE;
					end else if (cm < 3'd7) begin
						if (b == chunk_char(cm)) cm = cm + 3'd1;
						else cm = (b == "c") ? 3'd1 : 3'd0;
					end
				end
				ll = sat_inc(ll);
				if (b == CH_LF) fp = 1'b1;
			end
			PH_CSIZE: begin
				case (np)
					3'd0: begin
						if (!wsb) begin
							if (b == "+") np = 3'd1;
							else if (b == "-") np = 3'd2;
							else if (b == "0") np = 3'd3;
							else if (!hv[4]) begin na = LW'(hv[3:0]); np = 3'd5; end
							else np = 3'd7;
						end
					end
					3'd1, 3'd2: begin
						if (b == "0") np = np + 3'd2;
						else if (!hv[4]) begin
							if (np == 3'd1) na = LW'(hv[3:0]);
							np = np + 3'd4;
						end else np = 3'd7;
					end
					3'd3, 3'd4: begin
						if (xx || !hv[4]) begin
							if (np == 3'd3 && !hv[4]) na = LW'(hv[3:0]);
							np = np + 3'd2;
						end else np = 3'd7;
					end
					3'd5: begin
						if (!hv[4]) na = sat_digit(na, 1'b1, hv[3:0]); else np = 3'd7;
					end
					3'd6: if (hv[4]) np = 3'd7;
					default: ;
				endcase
				ll = sat_inc(ll);
				if (b == CH_LF) begin
					if (na != '0) begin cr = na; ph = PH_CDATA; end
					else ph = PH_TRAIL;
					ll = '0; fp = 1'b0; kw = KW_NONE; cm = '0; np = '0; na = '0; ss = '0;
				end
			end
			PH_CDATA: begin
				if (cr != '0) cr = cr - 1'b1;
				if (cr == '0) begin ll = '0; ph = PH_CCRLF; end
			end
			PH_CCRLF: begin
				ll = sat_inc(ll);
				if (b == CH_LF) begin
					ph = (ll == LW'(2)) ? PH_CSIZE : PH_FAIL;
					ll = '0; fp = 1'b0; kw = KW_NONE; cm = '0; np = '0; na = '0; ss = '0;
				end
			end
			PH_TRAIL: begin
				ll = sat_inc(ll);
				if (b == CH_LF) begin
					if (ll == LW'(2)) begin rl = bc; ph = PH_DONE; end
					ll = '0;
				end
			end
			PH_DONE, PH_TOEND: ;
			default: ph = PH_FAIL;
		endcase

		// End of buffer: close a dangling header line, then report.
		if (in_last) begin
			if (ph == PH_HEAD && fp) begin
				if (ll == LW'(2)) begin
					he = bc;
					if (isr && (cfg.head_request || sc == 10'd204 || sc == 10'd304 ||
							(sc >= 10'd100 && sc <= 10'd199))) begin
						rl = he; ph = PH_DONE;
					end else if (isr && cfg.connect_request && sc >= 10'd200 &&
							sc <= 10'd299) begin
						rl = he; ph = PH_DONE;
					end else if (chs) ph = PH_CSIZE;
					else if (clvd) begin rl = sat_add(he, clv); ph = PH_DONE; end
					else if (!isr) begin rl = he; ph = PH_DONE; end
					else if (cfg.conn_closed) ph = PH_TOEND;
					else ph = PH_FAIL;
				end
			end
			if (bc >= LW'(MIN_MESSAGE)) begin
				if (ph == PH_DONE) begin ok = 1'b1; olen = rl; end
				else if (ph == PH_TOEND) begin ok = 1'b1; olen = bc; end
			end
			if (olen > OUT_MAX) olen = OUT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD; byte_count_q <= '0; line_length_q <= '0;
			number_accum_q <= '0; clen_value_q <= '0; chunk_rem_q <= '0;
			hdr_end_q <= '0; result_len_q <= '0; fold_q <= 1'b0; is_resp_q <= 1'b0;
			clen_valid_q <= 1'b0; chunked_q <= 1'b0; sl_step_q <= '0; status_q <= '0;
			kw_q <= KW_NONE; cm_q <= '0; np_q <= '0;
			res_valid <= 1'b0; res_complete <= 1'b0; res_length <= '0;
		end else begin
			res_valid <= in_valid && in_last;
			if (in_valid) begin
				res_complete <= ok;
				res_length   <= 31'(olen);
				if (in_last) begin
					phase_q <= PH_LEAD; byte_count_q <= '0; line_length_q <= '0;
					number_accum_q <= '0; clen_value_q <= '0; chunk_rem_q <= '0;
					hdr_end_q <= '0; result_len_q <= '0; fold_q <= 1'b0;
					is_resp_q <= 1'b0; clen_valid_q <= 1'b0; chunked_q <= 1'b0;
					sl_step_q <= '0; status_q <= '0; kw_q <= KW_NONE; cm_q <= '0;
					np_q <= '0;
				end else begin
					phase_q <= ph; byte_count_q <= bc; line_length_q <= ll;
					number_accum_q <= na; clen_value_q <= clv; chunk_rem_q <= cr;
					hdr_end_q <= he; result_len_q <= rl; fold_q <= fp; is_resp_q <= isr;
					clen_valid_q <= clvd; chunked_q <= chs; sl_step_q <= ss;
					status_q <= sc; kw_q <= kw; cm_q <= cm; np_q <= np;
				end
			end
		end
	end

endmodule

@@ hw/rtl/hmlf_out_skid.sv @@
module hmlf_out_skid import hmlf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_complete,
	input  logic [30:0] in_length,
	output logic        in_stall,
	output logic        out_valid,
	output logic        out_complete,
	output logic [30:0] out_length,
	input  logic        out_stall
);

	// Main output register plus one skid entry.
	logic        main_v_q, skid_v_q;
	logic        main_c_q, skid_c_q;
	logic [30:0] main_l_q, skid_l_q;

	assign out_valid    = main_v_q;
	assign out_complete = main_c_q;
	assign out_length   = main_l_q;
	// A result arriving while the output register is held takes the skid entry, so the
	// octet source is held back in that cycle as well as while the skid entry is taken.
	assign in_stall     = skid_v_q || (in_valid && main_v_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
			main_c_q <= 1'b0;
			skid_c_q <= 1'b0;
			main_l_q <= '0;
			skid_l_q <= '0;
		end else begin
			if (!main_v_q || !out_stall) begin
				if (skid_v_q) begin
					main_v_q <= 1'b1; main_c_q <= skid_c_q; main_l_q <= skid_l_q;
					skid_v_q <= in_valid;
					skid_c_q <= in_complete; skid_l_q <= in_length;
				end else begin
					main_v_q <= in_valid; main_c_q <= in_complete; main_l_q <= in_length;
				end
			end else if (in_valid) begin
				skid_v_q <= 1'b1; skid_c_q <= in_complete; skid_l_q <= in_length;
			end
		end
	end

endmodule
